>>> rtl/s2l_pkg.sv
// Shared constants, table builder and types for the sRGB to CIE Lab converter.
package s2l_pkg;

  localparam int unsigned QBITS = 24;
  localparam int unsigned LINW  = QBITS + 1;
  localparam int unsigned SUMW  = 48;

  typedef logic [LINW-1:0] lin_t;
  typedef lin_t lut_t [256];
  typedef logic [23:0] coef_t;

  localparam coef_t MAT_COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };
  localparam coef_t WHITE_DIV [3] = '{24'd9504700, 24'd10000000, 24'd10888300};

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> QBITS;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] p;
    p = qmul(r, r);
    p = qmul(p, r);
    p = qmul(p, r);
    return qmul(p, r);
  endfunction

  // Linear light for every 8-bit code, worked out at elaboration.
  function automatic lut_t build_lut();
    lut_t        lut;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (c * 64'd100000 <= 64'd1031475) begin
        lut[i] = LINW'((c * 64'd10 << QBITS) / 64'd32946);
      end else begin
        t = ((64'd1000 * c + 64'd14025) << QBITS) / 64'd269025;
        r = '0;
        for (int b = 24; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          if (cand <= (64'd1 << QBITS) && pow5(cand) <= t) begin
            r = cand;
          end
        end
        lut[i] = LINW'(qmul(qmul(t, t), qmul(r, r)));
      end
    end
    return lut;
  endfunction

  localparam lut_t LIN_LUT = build_lut();

endpackage

>>> rtl/s2l_cbrt.sv
// Pipelined bit-by-bit cube root of a Q24 ratio, two register stages per result bit.
module s2l_cbrt
  import s2l_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [LINW-1:0] f_i,
  output logic            vld_o,
  output logic [LINW-1:0] q_o
);

  localparam int unsigned NB = LINW;

  logic            v_q  [NB+1];
  logic [LINW-1:0] q_q  [NB+1];
  logic [LINW-1:0] f_q  [NB+1];
  logic            va_q [NB];
  logic [LINW-1:0] qa_q [NB];
  logic [LINW-1:0] fa_q [NB];
  logic [LINW:0]   sq_q [NB];

  assign v_q[0] = vld_i;
  assign q_q[0] = '0;
  assign f_q[0] = f_i;

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam logic [LINW-1:0] BITM = LINW'(1) << (NB - 1 - k);
    logic [LINW-1:0]   cand_a;
    logic [LINW-1:0]   cand_b;
    logic [2*LINW-1:0] sq_full;
    logic [2*LINW:0]   cube_full;
    logic [LINW+1:0]   cube;
    logic [LINW:0]     sq_d;
    logic [LINW-1:0]   q_d;

    always_comb begin
      cand_a    = q_q[k] | BITM;
      sq_full   = cand_a * cand_a;
      sq_d      = sq_full[QBITS +: LINW+1];
      cand_b    = qa_q[k] | BITM;
      cube_full = sq_q[k] * cand_b;
      cube      = cube_full[QBITS +: LINW+2];
      q_d       = (cube <= {2'b00, fa_q[k]}) ? cand_b : qa_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[k]  <= 1'b0;
        v_q[k+1] <= 1'b0;
      end else begin
        va_q[k]  <= v_q[k];
        v_q[k+1] <= va_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      qa_q[k]  <= q_q[k];
      fa_q[k]  <= f_q[k];
      sq_q[k]  <= sq_d;
      q_q[k+1] <= q_d;
      f_q[k+1] <= fa_q[k];
    end
  end

  assign vld_o = v_q[NB];
  assign q_o   = q_q[NB];

endmodule

>>> rtl/srgb_to_cielab_converter_unit.sv
// Top level of the sRGB to CIE Lab (D65) pixel converter pipeline.
//
// One pixel is taken on every cycle in which start_i is high; busy_o is never
// raised, so the block sustains one pixel per clock. Each result is held on
// valid_o and the three output ports for a single cycle; it must be taken
// then. The pipeline is made of a table lookup, the matrix products and sums
// (three stages), a division by the white point made from a reciprocal
// product and one correction step (three stages), a 50-stage cube root that
// spends two multiplier stages on each result bit, and two output stages for
// scaling and rounding.
module srgb_to_cielab_converter_unit
  import s2l_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               valid_o,
  output logic signed [15:0] lightness_o,
  output logic signed [15:0] green_red_o,
  output logic signed [15:0] blue_yellow_o
);

  localparam int unsigned SHIFT = QBITS - FRAC_BITS;
  localparam int unsigned NDIV  = 3;
  localparam int unsigned LAT   = 3 + NDIV + 2 * LINW + 2;
  localparam int unsigned VW    = 40;
  localparam int unsigned RSH   = 16;
  localparam int unsigned EW    = SUMW - RSH + LINW;
  localparam int unsigned RW    = 27;

  assign busy_o = 1'b0;

  // Lookup and matrix stages.
  logic            v0_q, v1_q, v2_q;
  logic [LINW-1:0] lin_q  [3];
  logic [SUMW-1:0] prod_q [3][3];
  logic [SUMW-1:0] sum_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q[0] <= LIN_LUT[red_i];
    lin_q[1] <= LIN_LUT[green_i];
    lin_q[2] <= LIN_LUT[blue_i];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= SUMW'(MAT_COEF[r][c]) * SUMW'(lin_q[c]);
      end
      sum_q[r] <= prod_q[r][0] + prod_q[r][1] + prod_q[r][2];
    end
  end

  // Division by the white point. The top 32 bits of the sum times a truncated
  // reciprocal give a quotient that is at most two short; the remainder then
  // tells how many divisors to add back.
  logic [NDIV-1:0] dv_q;
  logic            cb_vld [3];
  logic [LINW-1:0] cb_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[NDIV-2:0], v2_q};
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam logic [SUMW-1:0] DIV   = SUMW'(WHITE_DIV[r]);
    localparam logic [LINW-1:0] RECIP = LINW'((64'd1 << SUMW) / 64'(WHITE_DIV[r]));
    localparam logic [RW-1:0]   DIV1  = RW'(WHITE_DIV[r]);
    localparam logic [RW-1:0]   DIV2  = RW'(2 * WHITE_DIV[r]);
    logic [EW-1:0]   est;
    logic [LINW-1:0] qe_q;
    logic [LINW-1:0] qe2_q;
    logic [LINW-1:0] quo_q;
    logic [SUMW-1:0] sd_q;
    logic [RW-1:0]   rem_q;

    always_comb begin
      est = sum_q[r][SUMW-1:RSH] * RECIP;
    end

    always_ff @(posedge clk_i) begin
      qe_q  <= est[EW-1 -: LINW];
      sd_q  <= sum_q[r];
      rem_q <= RW'(sd_q - qe_q * DIV);
      qe2_q <= qe_q;
      priority if (rem_q >= DIV2) begin
        quo_q <= qe2_q + LINW'(2);
      end else if (rem_q >= DIV1) begin
        quo_q <= qe2_q + LINW'(1);
      end else begin
        quo_q <= qe2_q;
      end
    end

    s2l_cbrt u_cbrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_q[NDIV-1]),
      .f_i    (quo_q),
      .vld_o  (cb_vld[r]),
      .q_o    (cb_q[r])
    );
  end

  // Output scaling, rounding and saturation.
  function automatic logic signed [15:0] round_sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + $signed(VW'(64'd1 << (SHIFT - 1)))) >>> SHIFT;
    if (r > VW'(32767)) return 16'sh7fff;
    if (r < -VW'(32768)) return 16'sh8000;
    return r[15:0];
  endfunction

  logic                 vs_q, vo_q;
  logic signed [VW-1:0] l_q, a_q, b_q;
  logic signed [VW-1:0] qx, qy, qz;

  always_comb begin
    qx = VW'(cb_q[0]);
    qy = VW'(cb_q[1]);
    qz = VW'(cb_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vs_q <= cb_vld[0];
      vo_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q           <= VW'(116) * qy - (VW'(16) <<< QBITS);
    a_q           <= VW'(500) * (qx - qy);
    b_q           <= VW'(200) * (qy - qz);
    lightness_o   <= round_sat(l_q);
    green_red_o   <= round_sat(a_q);
    blue_yellow_o <= round_sat(b_q);
  end

  assign valid_o = vo_q;

  // A result only ever follows a request that passed through the whole pipeline.
  a_result_has_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("result without a matching request");

  // The three cube-root lanes must stay in lock step.
  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cb_vld[0] == cb_vld[1]) && (cb_vld[0] == cb_vld[2]))
    else $error("cube-root lanes out of step");

endmodule
